FILE: rtl/madt_pkg.sv
// ----------------------------------------------------------------------------
// MADT stream parser package
// Shared constants, status codes, entry kinds and the entry size table used
// by the MADT stream parser.
// ----------------------------------------------------------------------------
package madt_pkg;

   localparam int HEADER_BYTES     = 36;
   localparam int OFFSET_BITS_DEF  = 20;
   localparam int RSP_DATA_BITS    = 264;
   localparam int RSP_USER_BITS    = 9;

   localparam logic [7:0] SIG_BYTE0 = 8'h41;
   localparam logic [7:0] SIG_BYTE1 = 8'h50;
   localparam logic [7:0] SIG_BYTE2 = 8'h49;
   localparam logic [7:0] SIG_BYTE3 = 8'h43;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_BAD_SIG   = 3'd1,
      STATUS_BAD_SUM   = 3'd2,
      STATUS_BAD_LEN   = 3'd3,
      STATUS_TRUNCATED = 3'd4
   } status_type;

   localparam logic [7:0] KIND_LAPIC     = 8'd0;
   localparam logic [7:0] KIND_IOAPIC    = 8'd1;
   localparam logic [7:0] KIND_OVERRIDE  = 8'd2;
   localparam logic [7:0] KIND_NMI_SRC   = 8'd3;
   localparam logic [7:0] KIND_LAPIC_NMI = 8'd4;
   localparam logic [7:0] KIND_LAPIC_ADR = 8'd5;
   localparam logic [7:0] KIND_X2APIC    = 8'd9;

   // Fixed entry size of a known kind, zero for a kind that is skipped.
   function automatic logic [7:0] fixed_size(input logic [7:0] kind);
      logic [7:0] size;
      unique case (kind)
         KIND_LAPIC:     size = 8'd8;
         KIND_IOAPIC:    size = 8'd12;
         KIND_OVERRIDE:  size = 8'd10;
         KIND_NMI_SRC:   size = 8'd8;
         KIND_LAPIC_NMI: size = 8'd6;
         KIND_LAPIC_ADR: size = 8'd12;
         KIND_X2APIC:    size = 8'd16;
         default:        size = 8'd0;
      endcase
      return size;
   endfunction

endpackage

FILE: rtl/acpi_madt_stream_parser.sv
// ----------------------------------------------------------------------------
// ACPI MADT stream parser
// Checks the header of an MADT table given one byte per beat, captures the
// controller words and decodes the known interrupt controller entries.
// ----------------------------------------------------------------------------
// Usage:
// The request channel carries one table byte per beat, and tlast marks the
// final byte of the table. The response channel carries one beat for every
// completed known entry and one for the final byte; both can fall on the
// same beat. tuser flags a decoded entry and gives its kind, tlast marks the
// table status beat, and tdata holds the decoded fields and the status.
// A byte is taken every cycle while no held response is stalled; its
// response appears in the cycle after the byte is accepted, held in the
// single output register after the per-byte state update. Bytes that
// produce no response leave the output untouched. When the receiver
// stalls, the held response keeps the request side stalled until it is
// taken. Reset clears the output valid flag and the parser state but the
// entry record; a final byte also resets that state for the next table.
// ----------------------------------------------------------------------------
module acpi_madt_stream_parser #(
   parameter int OFFSET_BITS = madt_pkg::OFFSET_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // data_byte
   input  logic                                req_tlast,   // byte_last
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // first_id[31:0], second_id[63:32], address[127:64],
   // interrupt_number[159:128], entry_flags[191:160], table_status[194:192],
   // controller_address[226:195], controller_flags[258:227], zero fill
   output logic [madt_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // entry_valid[0], entry_kind[8:1]
   output logic [madt_pkg::RSP_USER_BITS-1:0] rsp_tuser,
   output logic                                rsp_tlast    // table_done
);

   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};
   localparam logic [31:0] HDR     = 32'(madt_pkg::HEADER_BYTES);
   localparam logic [31:0] FLG_OFF = 32'(madt_pkg::HEADER_BYTES + 4);
   localparam logic [31:0] ENT_OFF = 32'(madt_pkg::HEADER_BYTES + 8);

   logic [OFFSET_BITS-1:0] byte_offset_ff, byte_offset_in;
   logic [7:0]             running_sum_ff, running_sum_in;
   logic [31:0]            table_length_ff, table_length_in;
   logic [7:0]             entry_position_ff, entry_position_in;
   logic [7:0]             entry_type_ff, entry_type_in;
   logic [7:0]             entry_length_ff, entry_length_in;
   logic [7:0]             record_ff [16];
   logic [7:0]             record_in [16];
   madt_pkg::status_type   error_code_ff, error_code_in;
   logic [31:0]            local_address_ff, local_address_in;
   logic [31:0]            table_flags_ff, table_flags_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [madt_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic [madt_pkg::RSP_USER_BITS-1:0] rsp_user_ff, rsp_user_in;
   logic                               rsp_last_ff, rsp_last_in;

   logic                 accept;
   logic [31:0]          off;
   logic [7:0]           need;
   logic                 emit;
   logic [1:0]           word_sel;
   logic [1:0]           hdr_sel;
   logic [1:0]           flg_sel;
   logic [3:0]           rec_idx;
   logic [31:0]          first_id, second_id, interrupt_number, entry_flags;
   logic [63:0]          address;
   madt_pkg::status_type status;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign off        = 32'(byte_offset_ff);
   assign need       = madt_pkg::fixed_size(entry_type_ff);
   assign word_sel   = off[1:0];
   assign hdr_sel    = 2'(off - HDR);
   assign flg_sel    = 2'(off - FLG_OFF);
   assign rec_idx    = 4'(entry_position_ff - 8'd2);

   always_comb begin
      byte_offset_in    = byte_offset_ff;
      running_sum_in    = running_sum_ff;
      table_length_in   = table_length_ff;
      entry_position_in = entry_position_ff;
      entry_type_in     = entry_type_ff;
      entry_length_in   = entry_length_ff;
      record_in         = record_ff;
      error_code_in     = error_code_ff;
      local_address_in  = local_address_ff;
      table_flags_in    = table_flags_ff;
      emit              = 1'b0;
      if (accept && byte_offset_ff != OFFSET_MAX) begin
         if (off < 32'd8 || off < table_length_ff) begin
            running_sum_in = running_sum_ff + req_tdata;
         end
         if (off < 32'd4) begin
            unique case (word_sel)
               2'd0:    if (req_tdata != madt_pkg::SIG_BYTE0 &&
                            error_code_ff == madt_pkg::STATUS_OK) begin
                  error_code_in = madt_pkg::STATUS_BAD_SIG;
               end
               2'd1:    if (req_tdata != madt_pkg::SIG_BYTE1 &&
                            error_code_ff == madt_pkg::STATUS_OK) begin
                  error_code_in = madt_pkg::STATUS_BAD_SIG;
               end
               2'd2:    if (req_tdata != madt_pkg::SIG_BYTE2 &&
                            error_code_ff == madt_pkg::STATUS_OK) begin
                  error_code_in = madt_pkg::STATUS_BAD_SIG;
               end
               default: if (req_tdata != madt_pkg::SIG_BYTE3 &&
                            error_code_ff == madt_pkg::STATUS_OK) begin
                  error_code_in = madt_pkg::STATUS_BAD_SIG;
               end
            endcase
         end else if (off < 32'd8) begin
            table_length_in[{word_sel, 3'b000} +: 8] = req_tdata;
            if (off == 32'd7 && table_length_in < ENT_OFF &&
                error_code_ff == madt_pkg::STATUS_OK) begin
               error_code_in = madt_pkg::STATUS_BAD_LEN;
            end
         end else if (off >= HDR && off < FLG_OFF) begin
            local_address_in[{hdr_sel, 3'b000} +: 8] = req_tdata;
         end else if (off >= FLG_OFF && off < ENT_OFF) begin
            table_flags_in[{flg_sel, 3'b000} +: 8] = req_tdata;
         end else if (off >= ENT_OFF && off < table_length_ff &&
                      error_code_ff == madt_pkg::STATUS_OK) begin
            if (entry_position_ff == 8'd0) begin
               entry_type_in     = req_tdata;
               entry_position_in = 8'd1;
            end else if (entry_position_ff == 8'd1) begin
               entry_length_in = req_tdata;
               if (req_tdata < 8'd2 || (need != 8'd0 && req_tdata != need)) begin
                  error_code_in     = madt_pkg::STATUS_BAD_LEN;
                  entry_position_in = 8'd0;
               end else if (req_tdata == 8'd2) begin
                  entry_position_in = 8'd0;
               end else begin
                  entry_position_in = 8'd2;
               end
            end else begin
               if (need != 8'd0) begin
                  record_in[rec_idx] = req_tdata;
               end
               if ({1'b0, entry_position_ff} + 9'd1 >= {1'b0, entry_length_ff}) begin
                  entry_position_in = 8'd0;
                  emit              = need != 8'd0;
               end else begin
                  entry_position_in = entry_position_ff + 8'd1;
               end
            end
         end
         byte_offset_in = byte_offset_ff + OFFSET_BITS'(1);
      end
   end

   always_comb begin
      first_id         = '0;
      second_id        = '0;
      address          = '0;
      interrupt_number = '0;
      entry_flags      = '0;
      if (emit) begin
         unique case (entry_type_ff)
            madt_pkg::KIND_LAPIC: begin
               first_id    = 32'(record_in[0]);
               second_id   = 32'(record_in[1]);
               entry_flags = {record_in[5], record_in[4], record_in[3], record_in[2]};
            end
            madt_pkg::KIND_IOAPIC: begin
               first_id         = 32'(record_in[0]);
               address          = 64'({record_in[5], record_in[4],
                                       record_in[3], record_in[2]});
               interrupt_number = {record_in[9], record_in[8], record_in[7], record_in[6]};
            end
            madt_pkg::KIND_OVERRIDE: begin
               first_id         = 32'(record_in[0]);
               second_id        = 32'(record_in[1]);
               entry_flags      = 32'({record_in[3], record_in[2]});
               interrupt_number = {record_in[7], record_in[6], record_in[5], record_in[4]};
            end
            madt_pkg::KIND_NMI_SRC: begin
               entry_flags      = 32'({record_in[1], record_in[0]});
               interrupt_number = {record_in[5], record_in[4], record_in[3], record_in[2]};
            end
            madt_pkg::KIND_LAPIC_NMI: begin
               first_id    = 32'(record_in[0]);
               entry_flags = 32'({record_in[2], record_in[1]});
               second_id   = 32'(record_in[3]);
            end
            madt_pkg::KIND_LAPIC_ADR: begin
               address = {record_in[9], record_in[8], record_in[7], record_in[6],
                          record_in[5], record_in[4], record_in[3], record_in[2]};
            end
            madt_pkg::KIND_X2APIC: begin
               first_id    = {record_in[5], record_in[4], record_in[3], record_in[2]};
               entry_flags = {record_in[9], record_in[8], record_in[7], record_in[6]};
               second_id   = {record_in[13], record_in[12], record_in[11], record_in[10]};
            end
            default: begin
               first_id = '0;
            end
         endcase
      end
   end

   always_comb begin
      priority if (error_code_in != madt_pkg::STATUS_OK) begin
         status = error_code_in;
      end else if (32'(byte_offset_in) < table_length_in) begin
         status = madt_pkg::STATUS_TRUNCATED;
      end else if (entry_position_in != 8'd0) begin
         status = madt_pkg::STATUS_BAD_LEN;
      end else if (running_sum_in != 8'd0) begin
         status = madt_pkg::STATUS_BAD_SUM;
      end else begin
         status = madt_pkg::STATUS_OK;
      end
   end

   always_comb begin
      rsp_valid_in = accept ? (emit || req_tlast) : (rsp_valid_ff && !rsp_tready);
      rsp_user_in  = {(emit ? entry_type_ff : 8'd0), emit};
      rsp_last_in  = req_tlast;
      rsp_data_in  = '0;
      rsp_data_in[31:0]    = first_id;
      rsp_data_in[63:32]   = second_id;
      rsp_data_in[127:64]  = address;
      rsp_data_in[159:128] = interrupt_number;
      rsp_data_in[191:160] = entry_flags;
      if (req_tlast) begin
         rsp_data_in[194:192] = status;
         rsp_data_in[226:195] = local_address_in;
         rsp_data_in[258:227] = table_flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_tlast)) begin
         byte_offset_ff    <= '0;
         running_sum_ff    <= '0;
         table_length_ff   <= '0;
         entry_position_ff <= '0;
         entry_type_ff     <= '0;
         entry_length_ff   <= '0;
         error_code_ff     <= madt_pkg::STATUS_OK;
         local_address_ff  <= '0;
         table_flags_ff    <= '0;
      end else begin
         byte_offset_ff    <= byte_offset_in;
         running_sum_ff    <= running_sum_in;
         table_length_ff   <= table_length_in;
         entry_position_ff <= entry_position_in;
         entry_type_ff     <= entry_type_in;
         entry_length_ff   <= entry_length_in;
         error_code_ff     <= error_code_in;
         local_address_ff  <= local_address_in;
         table_flags_ff    <= table_flags_in;
      end
   end

   always_ff @(posedge clock) begin
      record_ff <= record_in;
      if (accept && (emit || req_tlast)) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_entry_only_without_fault: assert property (@(posedge clock) disable iff (reset)
      entry_position_ff != 8'd0 |-> error_code_ff == madt_pkg::STATUS_OK)
      else $error("entry in progress while a fault is recorded");

   a_cleared_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> byte_offset_ff == '0 && entry_position_ff == 8'd0 &&
                              error_code_ff == madt_pkg::STATUS_OK)
      else $error("parser state not cleared after the final byte");

   a_no_empty_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[0] || rsp_tlast)
      else $error("response beat carries neither an entry nor a status");

   a_known_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         rsp_tuser[8:1] == madt_pkg::KIND_LAPIC || rsp_tuser[8:1] == madt_pkg::KIND_IOAPIC ||
         rsp_tuser[8:1] == madt_pkg::KIND_OVERRIDE ||
         rsp_tuser[8:1] == madt_pkg::KIND_NMI_SRC ||
         rsp_tuser[8:1] == madt_pkg::KIND_LAPIC_NMI ||
         rsp_tuser[8:1] == madt_pkg::KIND_LAPIC_ADR ||
         rsp_tuser[8:1] == madt_pkg::KIND_X2APIC)
      else $error("decoded entry of an unknown kind");

endmodule

FILE: dv/tb_acpi_madt_stream_parser.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the ACPI MADT stream parser
// Builds MADT tables byte by byte, some well formed and some with header,
// entry, length, checksum or truncation faults, and streams them through
// the request channel. A behavioral model of the parser predicts every
// response beat, and each beat taken from the response channel is compared
// field by field with the oldest prediction. Sender gaps and receiver
// stalls vary by phase, and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module tb_acpi_madt_stream_parser;

   localparam int          OFFSET_W     = 12;
   localparam int unsigned OFFSET_MAX   = (1 << OFFSET_W) - 1;
   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          HOLD_CYCLES  = 400;
   localparam int          RANDOM_BYTES = 840;

   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_mode_type;

   typedef struct {
      logic        entry_valid;
      logic [7:0]  entry_kind;
      logic [31:0] first_id;
      logic [31:0] second_id;
      logic [63:0] address;
      logic [31:0] interrupt_number;
      logic [31:0] entry_flags;
      logic        table_done;
      logic [2:0]  table_status;
      logic [31:0] controller_address;
      logic [31:0] controller_flags;
   } madt_record_type;

   logic                               clock      = 1'b0;
   logic                               reset      = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [7:0]                         req_tdata  = 8'h00;
   logic                               req_tlast  = 1'b0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [madt_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic [madt_pkg::RSP_USER_BITS-1:0] rsp_tuser;
   logic                               rsp_tlast;

   madt_record_type pending_records[$];
   logic [7:0]      entry_bytes[$];
   logic [7:0]      table_bytes[$];

   int mismatches    = 0;
   int cycle_count   = 0;
   int bytes_sent    = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   // Parser model state.
   int unsigned          bytes_taken;
   logic [7:0]           sum_acc;
   logic [31:0]          decl_len;
   logic [7:0]           ent_pos;
   logic [7:0]           ent_kind;
   logic [7:0]           ent_len;
   logic [127:0]         ent_body;
   madt_pkg::status_type fault;
   logic [31:0]          ctrl_addr;
   logic [31:0]          ctrl_flags;

   acpi_madt_stream_parser #(
      .OFFSET_BITS(OFFSET_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_acpi_madt_stream_parser: FAIL");
         $finish;
      end
   end

   function automatic int unsigned entry_size(input logic [7:0] kind);
      case (kind)
         madt_pkg::KIND_LAPIC:     return 8;
         madt_pkg::KIND_IOAPIC:    return 12;
         madt_pkg::KIND_OVERRIDE:  return 10;
         madt_pkg::KIND_NMI_SRC:   return 8;
         madt_pkg::KIND_LAPIC_NMI: return 6;
         madt_pkg::KIND_LAPIC_ADR: return 12;
         madt_pkg::KIND_X2APIC:    return 16;
         default:                  return 0;
      endcase
   endfunction

   function automatic logic [7:0] known_kind(input int idx);
      case (idx)
         0:       return madt_pkg::KIND_LAPIC;
         1:       return madt_pkg::KIND_IOAPIC;
         2:       return madt_pkg::KIND_OVERRIDE;
         3:       return madt_pkg::KIND_NMI_SRC;
         4:       return madt_pkg::KIND_LAPIC_NMI;
         5:       return madt_pkg::KIND_LAPIC_ADR;
         default: return madt_pkg::KIND_X2APIC;
      endcase
   endfunction

   function automatic logic [7:0] signature_byte(input int unsigned idx);
      case (idx)
         0:       return madt_pkg::SIG_BYTE0;
         1:       return madt_pkg::SIG_BYTE1;
         2:       return madt_pkg::SIG_BYTE2;
         default: return madt_pkg::SIG_BYTE3;
      endcase
   endfunction

   // Little-endian field of n bytes that starts at entry byte pos.
   function automatic logic [63:0] body_field(input int unsigned pos, input int unsigned n);
      logic [127:0] shifted;
      logic [63:0]  mask;
      shifted = ent_body >> (8 * (pos - 2));
      mask    = (n >= 8) ? {64{1'b1}} : ((64'd1 << (8 * n)) - 64'd1);
      return shifted[63:0] & mask;
   endfunction

   task automatic clear_parser_model();
      bytes_taken = 0;
      sum_acc     = 8'h00;
      decl_len    = 32'h0;
      ent_pos     = 8'h00;
      ent_kind    = 8'h00;
      ent_len     = 8'h00;
      ent_body    = '0;
      fault       = madt_pkg::STATUS_OK;
      ctrl_addr   = 32'h0;
      ctrl_flags  = 32'h0;
   endtask

   task automatic predict_byte(input logic [7:0] b, input logic last);
      madt_record_type      rec;
      bit                   emit;
      int unsigned          off;
      int unsigned          need;
      madt_pkg::status_type st;
      rec = '{default: '0};
      emit = 1'b0;
      if (bytes_taken < OFFSET_MAX) begin
         off = bytes_taken;
         if (off < 8 || off < decl_len) sum_acc = sum_acc + b;
         if (off < 4) begin
            if (b != signature_byte(off) && fault == madt_pkg::STATUS_OK)
               fault = madt_pkg::STATUS_BAD_SIG;
         end else if (off < 8) begin
            decl_len[8*(off-4) +: 8] = b;
            if (off == 7 && decl_len < madt_pkg::HEADER_BYTES + 8 &&
                fault == madt_pkg::STATUS_OK)
               fault = madt_pkg::STATUS_BAD_LEN;
         end else if (off >= madt_pkg::HEADER_BYTES && off < madt_pkg::HEADER_BYTES + 4) begin
            ctrl_addr[8*(off-madt_pkg::HEADER_BYTES) +: 8] = b;
         end else if (off >= madt_pkg::HEADER_BYTES + 4 &&
                      off < madt_pkg::HEADER_BYTES + 8) begin
            ctrl_flags[8*(off-madt_pkg::HEADER_BYTES-4) +: 8] = b;
         end else if (off >= madt_pkg::HEADER_BYTES + 8 && off < decl_len &&
                      fault == madt_pkg::STATUS_OK) begin
            need = entry_size(ent_kind);
            if (ent_pos == 0) begin
               ent_kind = b;
               ent_body = '0;
               ent_pos  = 8'd1;
            end else if (ent_pos == 1) begin
               ent_len = b;
               if (b < 2 || (need != 0 && b != need)) begin
                  fault   = madt_pkg::STATUS_BAD_LEN;
                  ent_pos = 8'd0;
               end else if (b == 2) begin
                  ent_pos = 8'd0;
               end else begin
                  ent_pos = 8'd2;
               end
            end else begin
               if (need != 0) ent_body[8*((ent_pos-2) & 15) +: 8] = b;
               if (ent_pos + 1 >= ent_len) begin
                  ent_pos = 8'd0;
                  emit    = (need != 0);
               end else begin
                  ent_pos = ent_pos + 8'd1;
               end
            end
         end
         bytes_taken = off + 1;
      end

      if (emit) begin
         rec.entry_valid = 1'b1;
         rec.entry_kind  = ent_kind;
         case (ent_kind)
            madt_pkg::KIND_LAPIC: begin
               rec.first_id    = 32'(body_field(2, 1));
               rec.second_id   = 32'(body_field(3, 1));
               rec.entry_flags = 32'(body_field(4, 4));
            end
            madt_pkg::KIND_IOAPIC: begin
               rec.first_id         = 32'(body_field(2, 1));
               rec.address          = body_field(4, 4);
               rec.interrupt_number = 32'(body_field(8, 4));
            end
            madt_pkg::KIND_OVERRIDE: begin
               rec.first_id         = 32'(body_field(2, 1));
               rec.second_id        = 32'(body_field(3, 1));
               rec.entry_flags      = 32'(body_field(4, 2));
               rec.interrupt_number = 32'(body_field(6, 4));
            end
            madt_pkg::KIND_NMI_SRC: begin
               rec.entry_flags      = 32'(body_field(2, 2));
               rec.interrupt_number = 32'(body_field(4, 4));
            end
            madt_pkg::KIND_LAPIC_NMI: begin
               rec.first_id    = 32'(body_field(2, 1));
               rec.entry_flags = 32'(body_field(3, 2));
               rec.second_id   = 32'(body_field(5, 1));
            end
            madt_pkg::KIND_LAPIC_ADR: begin
               rec.address = body_field(4, 8);
            end
            default: begin
               rec.first_id    = 32'(body_field(4, 4));
               rec.entry_flags = 32'(body_field(8, 4));
               rec.second_id   = 32'(body_field(12, 4));
            end
         endcase
      end

      if (last) begin
         if (fault != madt_pkg::STATUS_OK) st = fault;
         else if (bytes_taken < decl_len)  st = madt_pkg::STATUS_TRUNCATED;
         else if (ent_pos != 0)            st = madt_pkg::STATUS_BAD_LEN;
         else if (sum_acc != 0)            st = madt_pkg::STATUS_BAD_SUM;
         else                              st = madt_pkg::STATUS_OK;
         rec.table_done         = 1'b1;
         rec.table_status       = st;
         rec.controller_address = ctrl_addr;
         rec.controller_flags   = ctrl_flags;
         clear_parser_model();
      end

      if (emit || last) pending_records.push_back(rec);
   endtask

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatches = mismatches + 1;
      end
   endtask

   always @(posedge clock) begin
      madt_record_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (pending_records.size() == 0) begin
            $error("response beat: expected none, got kind %h last %b", rsp_tuser[8:1], rsp_tlast);
            mismatches = mismatches + 1;
         end else begin
            want = pending_records.pop_front();
            check_field("entry_valid", 64'(want.entry_valid), 64'(rsp_tuser[0]));
            check_field("entry_kind", 64'(want.entry_kind), 64'(rsp_tuser[8:1]));
            check_field("first_id", 64'(want.first_id), 64'(rsp_tdata[31:0]));
            check_field("second_id", 64'(want.second_id), 64'(rsp_tdata[63:32]));
            check_field("address", want.address, rsp_tdata[127:64]);
            check_field("interrupt_number", 64'(want.interrupt_number),
                        64'(rsp_tdata[159:128]));
            check_field("entry_flags", 64'(want.entry_flags), 64'(rsp_tdata[191:160]));
            check_field("table_done", 64'(want.table_done), 64'(rsp_tlast));
            check_field("table_status", 64'(want.table_status), 64'(rsp_tdata[194:192]));
            check_field("controller_address", 64'(want.controller_address),
                        64'(rsp_tdata[226:195]));
            check_field("controller_flags", 64'(want.controller_flags),
                        64'(rsp_tdata[258:227]));
         end
      end
   end

   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_left   = HOLD_CYCLES;
         hold_served = hold_served + 1;
      end
      if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_byte(b, last);
      bytes_sent = bytes_sent + 1;
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_records.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic add_entry(input logic [7:0] kind, input logic [7:0] len,
                            input fill_mode_type fill);
      int i;
      entry_bytes.push_back(kind);
      entry_bytes.push_back(len);
      for (i = 2; i < len; i++) begin
         case (fill)
            FILL_ZERO: entry_bytes.push_back(8'h00);
            FILL_ONES: entry_bytes.push_back(8'hFF);
            default:   entry_bytes.push_back(8'($urandom));
         endcase
      end
   endtask

   task automatic set_length(input logic [31:0] len);
      table_bytes[4] = len[7:0];
      table_bytes[5] = len[15:8];
      table_bytes[6] = len[23:16];
      table_bytes[7] = len[31:24];
   endtask

   // Rewrites the checksum byte so that the summed bytes add up to zero.
   task automatic seal_checksum();
      logic [7:0]  s;
      logic [31:0] len;
      int          i;
      len = {table_bytes[7], table_bytes[6], table_bytes[5], table_bytes[4]};
      s = 8'h00;
      for (i = 0; i < table_bytes.size(); i++)
         if (i != 9 && (i < 8 || i < len)) s = s + table_bytes[i];
      table_bytes[9] = 8'h00 - s;
   endtask

   task automatic build_table();
      int i;
      table_bytes.delete();
      for (i = 0; i < madt_pkg::HEADER_BYTES + 8; i++) table_bytes.push_back(8'($urandom));
      for (i = 0; i < 4; i++) table_bytes[i] = signature_byte(i);
      foreach (entry_bytes[i]) table_bytes.push_back(entry_bytes[i]);
      entry_bytes.delete();
      set_length(table_bytes.size());
      seal_checksum();
   endtask

   task automatic send_table();
      int i;
      for (i = 0; i < table_bytes.size(); i++)
         send_byte(table_bytes[i], i == table_bytes.size() - 1);
   endtask

   task automatic test_known_entries();
      int k;
      int i;
      for (k = 0; k < 7; k++)
         add_entry(known_kind(k), 8'(entry_size(known_kind(k))), FILL_ONES);
      add_entry(8'hFF, 8'd2, FILL_RANDOM);
      add_entry(8'd6, 8'd9, FILL_ONES);
      build_table();
      for (i = madt_pkg::HEADER_BYTES; i < madt_pkg::HEADER_BYTES + 8; i++)
         table_bytes[i] = 8'hFF;
      seal_checksum();
      send_table();
      for (k = 6; k >= 0; k--)
         add_entry(known_kind(k), 8'(entry_size(known_kind(k))), FILL_ZERO);
      build_table();
      for (i = madt_pkg::HEADER_BYTES; i < madt_pkg::HEADER_BYTES + 8; i++)
         table_bytes[i] = 8'h00;
      seal_checksum();
      send_table();
      wait_for_results();
   endtask

   task automatic test_header_faults();
      add_entry(madt_pkg::KIND_LAPIC, 8'd8, FILL_RANDOM);
      add_entry(madt_pkg::KIND_IOAPIC, 8'd12, FILL_RANDOM);
      build_table();
      table_bytes[2] = table_bytes[2] ^ 8'h20;
      send_table();

      add_entry(madt_pkg::KIND_LAPIC_NMI, 8'd6, FILL_RANDOM);
      build_table();
      table_bytes[table_bytes.size() - 1] = table_bytes[table_bytes.size() - 1] ^ 8'h01;
      send_table();

      add_entry(madt_pkg::KIND_LAPIC, 8'd8, FILL_RANDOM);
      build_table();
      set_length(madt_pkg::HEADER_BYTES + 7);
      seal_checksum();
      send_table();

      add_entry(madt_pkg::KIND_NMI_SRC, 8'd8, FILL_RANDOM);
      build_table();
      set_length(32'hFFFF_FFFF);
      seal_checksum();
      send_table();

      table_bytes.delete();
      table_bytes.push_back(madt_pkg::SIG_BYTE0);
      send_table();

      add_entry(madt_pkg::KIND_OVERRIDE, 8'd10, FILL_RANDOM);
      build_table();
      repeat (3) table_bytes.push_back(8'($urandom));
      send_table();
      wait_for_results();
   endtask

   task automatic test_entry_faults();
      add_entry(madt_pkg::KIND_LAPIC, 8'd8, FILL_RANDOM);
      add_entry(madt_pkg::KIND_IOAPIC, 8'd0, FILL_RANDOM);
      add_entry(madt_pkg::KIND_LAPIC, 8'd8, FILL_RANDOM);
      build_table();
      send_table();

      add_entry(8'd7, 8'd1, FILL_RANDOM);
      add_entry(madt_pkg::KIND_LAPIC, 8'd8, FILL_RANDOM);
      build_table();
      send_table();

      add_entry(madt_pkg::KIND_X2APIC, 8'd12, FILL_RANDOM);
      add_entry(madt_pkg::KIND_LAPIC, 8'd8, FILL_RANDOM);
      build_table();
      send_table();

      add_entry(madt_pkg::KIND_X2APIC, 8'd16, FILL_RANDOM);
      add_entry(madt_pkg::KIND_IOAPIC, 8'd12, FILL_RANDOM);
      build_table();
      set_length(table_bytes.size() - 5);
      repeat (5) table_bytes.pop_back();
      seal_checksum();
      send_table();
      wait_for_results();
   endtask

   task automatic test_receiver_hold_off();
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_requests = hold_requests + 1;
      repeat (12) add_entry(madt_pkg::KIND_LAPIC, 8'd8, FILL_RANDOM);
      add_entry(madt_pkg::KIND_LAPIC_NMI, 8'd6, FILL_RANDOM);
      build_table();
      send_table();
      wait_for_results();
   endtask

   task automatic test_random_tables();
      int          phase;
      int          goal;
      int          n;
      int          c;
      int          k;
      int          nb;
      logic [7:0]  kind;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 64; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 64; end
            default: begin send_idle_pct = 7;  stall_pct = 7;  end
         endcase
         goal = bytes_sent + RANDOM_BYTES / 4;
         while (bytes_sent < goal) begin
            n = $urandom_range(0, 7);
            repeat (n) begin
               c = $urandom_range(99);
               if (c < 80) begin
                  kind = known_kind($urandom_range(6));
                  add_entry(kind, 8'(entry_size(kind)),
                            ($urandom_range(9) < 8) ? FILL_RANDOM :
                            ($urandom_range(1) ? FILL_ZERO : FILL_ONES));
               end else if (c < 95) begin
                  do kind = 8'($urandom); while (entry_size(kind) != 0);
                  add_entry(kind, 8'($urandom_range(2, 24)), FILL_RANDOM);
               end else begin
                  kind = $urandom_range(1) ? known_kind($urandom_range(6)) : 8'($urandom);
                  add_entry(kind, 8'($urandom_range(0, 20)), FILL_RANDOM);
               end
            end
            nb = entry_bytes.size();
            build_table();
            c = $urandom_range(99);
            if (c < 70) begin
            end else if (c < 75) begin
               k = $urandom_range(3);
               table_bytes[k] = table_bytes[k] ^ (8'h01 << $urandom_range(7));
            end else if (c < 80) begin
               k = $urandom_range(table_bytes.size() - 1);
               table_bytes[k] = table_bytes[k] ^ 8'($urandom_range(1, 255));
            end else if (c < 85) begin
               if ($urandom_range(1)) begin
                  set_length($urandom);
                  seal_checksum();
               end else begin
                  k = $urandom_range(1, table_bytes.size() - 1);
                  repeat (k) table_bytes.pop_back();
               end
            end else if (c < 89) begin
               repeat ($urandom_range(1, 8)) table_bytes.push_back(8'($urandom));
            end else if (c < 93) begin
               if (nb > 0) begin
                  k = $urandom_range(1, nb);
                  set_length(table_bytes.size() - k);
                  repeat (k) table_bytes.pop_back();
                  seal_checksum();
               end
            end else if (c < 96) begin
               set_length($urandom_range(0, madt_pkg::HEADER_BYTES + 7));
               seal_checksum();
            end else begin
               table_bytes.delete();
               repeat ($urandom_range(1, 60)) table_bytes.push_back(8'($urandom));
            end
            send_table();
         end
         wait_for_results();
      end
   endtask

   initial begin
      clear_parser_model();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_known_entries();
      test_header_faults();
      test_entry_faults();
      test_receiver_hold_off();
      test_random_tables();
      wait_for_results();
      if (mismatches == 0) begin
         $display("tb_acpi_madt_stream_parser: PASS");
      end else begin
         $display("tb_acpi_madt_stream_parser: FAIL");
      end
      $finish;
   end

endmodule
